@@ rtl/lmcr_pkg.sv @@
// shared types, constants and frame helpers for the led matrix chain refresher
// no dependencies; imported by every module under rtl
package lmcr_pkg;

	localparam int NUM_DEVICES  = 4;
	localparam int PANEL_HEIGHT = 32;
	localparam int PANEL_WIDTH  = 8;

	// frame is always four 16-bit slots wide; slots past the chain stay no-op
	localparam int MAX_SLOTS = 4;
	localparam int SLOT_W    = 2;
	localparam int FRAME_W   = 16 * MAX_SLOTS;
	localparam int ROW_W     = $clog2(PANEL_HEIGHT);
	localparam int STEP_W    = 3;

	localparam int X_W = 4;
	localparam int Y_W = 6;

	// driver register codes
	localparam logic [7:0] REG_NOOP       = 8'h00;
	localparam logic [7:0] REG_DIGIT_BASE = 8'h01;
	localparam logic [7:0] REG_DECODE     = 8'h09;
	localparam logic [7:0] REG_INTENSITY  = 8'h0A;
	localparam logic [7:0] REG_SCAN       = 8'h0B;
	localparam logic [7:0] REG_SHUTDOWN   = 8'h0C;
	localparam logic [7:0] REG_TEST       = 8'h0F;

	// init steps per device
	localparam logic [STEP_W-1:0] STEP_SHUTDOWN  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_TEST      = 3'd1;
	localparam logic [STEP_W-1:0] STEP_DECODE    = 3'd2;
	localparam logic [STEP_W-1:0] STEP_SCAN      = 3'd3;
	localparam logic [STEP_W-1:0] STEP_INTENSITY = 3'd4;

	// configuration register indexes
	localparam logic REG_IDX_INTENSITY = 1'b0;
	localparam logic REG_IDX_SCAN      = 1'b1;

	typedef enum logic [1:0] {
		CMD_SET_PIXEL = 2'd0,
		CMD_CLEAR     = 2'd1,
		CMD_FLUSH     = 2'd2,
		CMD_INIT      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic              wr_pixel;
		logic              clear;
		logic              load;
		logic              is_init;
		logic [SLOT_W-1:0] dev;
		logic [STEP_W-1:0] step;
		logic [ROW_W-1:0]  row;
		logic              last;
	} lmcr_ctl_t;

	typedef struct packed {
		logic out_free;
	} lmcr_stat_t;

	function automatic logic [15:0] init_word(input logic [STEP_W-1:0] step,
			input logic [2:0] scan, input logic [3:0] intens);
		logic [15:0] w;
		w = {REG_NOOP, 8'h00};
		case (step)
			STEP_SHUTDOWN:  w = {REG_SHUTDOWN, 8'h01};
			STEP_TEST:      w = {REG_TEST, 8'h00};
			STEP_DECODE:    w = {REG_DECODE, 8'h00};
			STEP_SCAN:      w = {REG_SCAN, 5'd0, scan};
			STEP_INTENSITY: w = {REG_INTENSITY, 4'd0, intens};
			default:        w = {REG_NOOP, 8'h00};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/lmcr_ctrl.sv @@
// command sequencer: accepts commands and walks the init and flush runs
// depends on lmcr_pkg
module lmcr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lmcr_pkg::cmd_t      cmd,
	input  lmcr_pkg::lmcr_stat_t stat,
	output lmcr_pkg::lmcr_ctl_t ctl
);
	import lmcr_pkg::*;

	state_t            state_q, state_d;
	logic [SLOT_W-1:0] dev_q, dev_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic              acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dev_q   <= '0;
			step_q  <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			dev_q   <= dev_d;
			step_q  <= step_d;
			row_q   <= row_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		dev_d       = dev_q;
		step_d      = step_q;
		row_d       = row_q;
		in_ready    = 1'b0;
		acc         = 1'b0;
		ctl         = '0;
		ctl.dev     = dev_q;
		ctl.step    = step_q;
		ctl.row     = row_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc) begin
					ctl.wr_pixel = (cmd == CMD_SET_PIXEL);
					ctl.clear    = (cmd == CMD_CLEAR) || (cmd == CMD_INIT);
					dev_d        = '0;
					step_d       = '0;
					row_d        = '0;
					unique case (cmd)
						CMD_SET_PIXEL:       state_d = ST_IDLE;
						CMD_INIT:            state_d = ST_INIT;
						CMD_CLEAR, CMD_FLUSH: state_d = ST_FLUSH;
						default:             state_d = ST_IDLE;
					endcase
				end
			end
			ST_INIT: begin
				ctl.is_init = 1'b1;
				if (stat.out_free) begin
					ctl.load = 1'b1;
					if (step_q == STEP_INTENSITY) begin
						step_d = '0;
						if (dev_q == SLOT_W'(NUM_DEVICES - 1)) begin
							state_d = ST_FLUSH;
						end else begin
							dev_d = dev_q + SLOT_W'(1);
						end
					end else begin
						step_d = step_q + STEP_W'(1);
					end
				end
			end
			ST_FLUSH: begin
				ctl.last = (row_q == ROW_W'(PANEL_HEIGHT - 1));
				if (stat.out_free) begin
					ctl.load = 1'b1;
					if (ctl.last) begin
						state_d = ST_IDLE;
					end else begin
						row_d = row_q + ROW_W'(1);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/lmcr_datapath.sv @@
// row store, frame assembly and the output register
// depends on lmcr_pkg; driven by lmcr_ctrl
module lmcr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lmcr_pkg::lmcr_ctl_t           ctl,
	output lmcr_pkg::lmcr_stat_t          stat,
	input  logic [lmcr_pkg::X_W-1:0]      px_x,
	input  logic [lmcr_pkg::Y_W-1:0]      px_y,
	input  logic                          px_on,
	input  logic [3:0]                    intensity,
	input  logic [2:0]                    scan,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lmcr_pkg::FRAME_W-1:0]  out_frame,
	output logic                          out_last
);
	import lmcr_pkg::*;

	logic [7:0]         row_q [PANEL_HEIGHT];
	logic [FRAME_W-1:0] frame_q;
	logic               last_q;
	logic               valid_q;

	logic               px_in_panel;
	logic [15:0]        word;
	logic [SLOT_W-1:0]  sel;
	logic [FRAME_W-1:0] frame_d;

	assign px_in_panel = (px_x < X_W'(PANEL_WIDTH)) && (px_y < Y_W'(PANEL_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < PANEL_HEIGHT; r++) row_q[r] <= '0;
		end else if (ctl.clear) begin
			for (int r = 0; r < PANEL_HEIGHT; r++) row_q[r] <= '0;
		end else if (ctl.wr_pixel && px_in_panel) begin
			// column x is bit 7-x of the row
			row_q[px_y[ROW_W-1:0]][~px_x[2:0]] <= px_on;
		end
	end

	always_comb begin
		if (ctl.is_init) begin
			word = init_word(ctl.step, scan, intensity);
			sel  = ctl.dev;
		end else begin
			word = {REG_DIGIT_BASE + {5'd0, ctl.row[2:0]}, row_q[ctl.row]};
			sel  = SLOT_W'(ctl.row >> 3);
		end
		for (int d = 0; d < MAX_SLOTS; d++) begin
			if (d < NUM_DEVICES && sel == SLOT_W'(d)) begin
				frame_d[16*d +: 16] = word;
			end else begin
				frame_d[16*d +: 16] = {REG_NOOP, 8'h00};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			frame_q <= frame_d;
			last_q  <= ctl.last;
		end
	end

	assign stat.out_free = !valid_q || out_ready;
	assign out_valid     = valid_q;
	assign out_frame     = frame_q;
	assign out_last      = last_q;

endmodule

@@ rtl/led_matrix_chain_refresher.sv @@
// top level of the led matrix chain refresher: stream ports, config registers
// depends on lmcr_pkg, lmcr_ctrl, lmcr_datapath
//
//   port group   dir   payload                                   accepted when
//   s_axis_*     in    tdata: cmd, x, y, pixel_on                tvalid & tready
//   m_axis_*     out   tdata: chain_frame, tlast: last           tvalid & tready
//   apb          in    intensity_level @0x0, scan_limit @0x4     psel&penable&pwrite
//
// set pixel leaves the sequencer idle; the next command is taken in the following cycle
// flush and clear emit 32 frames, init emits 52, one frame per cycle unless
// m_axis_tready stalls the output register; s_axis_tready is low for the run
// and rises the cycle after the final frame is loaded
// the output register lets the next command start while the final frame waits
// arst_n clears the row store, the sequencer and the output valid at once
module led_matrix_chain_refresher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // cmd[1:0], x[5:2], y[11:6], pixel_on[12], zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // chain_frame[63:0]
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lmcr_pkg::*;

	cmd_t       cmd;
	lmcr_ctl_t  ctl;
	lmcr_stat_t stat;
	logic [3:0] intensity_q;
	logic [2:0] scan_q;
	logic       cfg_wr;

	assign cmd = cmd_t'(s_axis_tdata[1:0]);

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_q <= 4'd8;
			scan_q      <= 3'd7;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_IDX_INTENSITY: intensity_q <= pwdata[3:0];
				REG_IDX_SCAN:      scan_q      <= pwdata[2:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IDX_INTENSITY: prdata = {28'd0, intensity_q};
			REG_IDX_SCAN:      prdata = {29'd0, scan_q};
			default:           prdata = '0;
		endcase
	end

	lmcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.stat     (stat),
		.ctl      (ctl)
	);

	lmcr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.px_x      (s_axis_tdata[5:2]),
		.px_y      (s_axis_tdata[11:6]),
		.px_on     (s_axis_tdata[12]),
		.intensity (intensity_q),
		.scan      (scan_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_frame (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	// a run command keeps the input side closed in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != CMD_SET_PIXEL)
		|=> !s_axis_tready)
		else $error("input side open right after a run command");

	// a pixel write never produces a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == CMD_SET_PIXEL
			&& (!m_axis_tvalid || m_axis_tready))
		|=> !m_axis_tvalid)
		else $error("frame emitted after a pixel write");

endmodule

@@ tb/led_matrix_chain_refresher_tb.sv @@
// testbench for led_matrix_chain_refresher: stream driver, frame monitor, apb writes
// predicts every chip-select frame from its own pixel row copy and config copy
// depends on lmcr_pkg and the rtl top level only
`timescale 1ns / 100ps

module led_matrix_chain_refresher_tb;
	import lmcr_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 64;
	localparam int RANDOM_ITEMS   = 115;
	localparam logic [2:0] ADDR_INTENSITY = {REG_IDX_INTENSITY, 2'b00};
	localparam logic [2:0] ADDR_SCAN      = {REG_IDX_SCAN, 2'b00};

	typedef struct {
		cmd_t       cmd;
		logic [3:0] x;
		logic [5:0] y;
		logic       on;
		bit         drain;   // hold this command until every frame has come back
	} cmd_item_t;

	typedef struct {
		logic [63:0] chain_frame;
		logic        last;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	cmd_item_t cmd_queue[$];
	frame_t    frames_due[$];
	logic [7:0] pixel_rows [PANEL_HEIGHT];
	logic [3:0] cfg_intensity = 4'd8;
	logic [2:0] cfg_scan = 3'd7;
	int send_idle_pct = 14;
	int recv_idle_pct = 68;
	int err_count = 0;
	int quiet_cycles = 0;

	led_matrix_chain_refresher dut (.*);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [63:0] device_frame(input int dev, input logic [7:0] code,
			input logic [7:0] data);
		logic [63:0] f;
		f = '0;
		for (int d = 0; d < NUM_DEVICES; d++)
			if (d == dev)
				f |= 64'({code, data}) << (16 * d);
			else
				f |= 64'({REG_NOOP, 8'h00}) << (16 * d);
		return f;
	endfunction

	function automatic void push_frame(input int dev, input logic [7:0] code,
			input logic [7:0] data);
		frame_t f;
		f.chain_frame = device_frame(dev, code, data);
		f.last = 1'b0;
		frames_due.push_back(f);
	endfunction

	// updates the row copy and queues the frames one accepted command produces
	function automatic void predict_frames(input logic [15:0] word);
		cmd_t       op;
		logic [3:0] px;
		logic [5:0] py;
		logic       lit;
		op  = cmd_t'(word[1:0]);
		px  = word[5:2];
		py  = word[11:6];
		lit = word[12];
		if (op == CMD_SET_PIXEL) begin
			if (px < PANEL_WIDTH && py < PANEL_HEIGHT)
				pixel_rows[py][7 - px] = lit;
		end else begin
			if (op == CMD_INIT)
				for (int d = 0; d < NUM_DEVICES; d++) begin
					push_frame(d, REG_SHUTDOWN, 8'h01);
					push_frame(d, REG_TEST, 8'h00);
					push_frame(d, REG_DECODE, 8'h00);
					push_frame(d, REG_SCAN, {5'd0, cfg_scan});
					push_frame(d, REG_INTENSITY, {4'd0, cfg_intensity});
				end
			if (op == CMD_CLEAR || op == CMD_INIT)
				for (int r = 0; r < PANEL_HEIGHT; r++)
					pixel_rows[r] = 8'h00;
			for (int r = 0; r < PANEL_HEIGHT; r++)
				push_frame(r / 8, REG_DIGIT_BASE + 8'(r % 8), pixel_rows[r]);
			frames_due[frames_due.size() - 1].last = 1'b1;
		end
	endfunction

	// stream driver: offers the next pending command once the previous one is taken
	// a run command taken at this edge still counts as frames outstanding
	always @(posedge clk or negedge arst_n) begin : drive_cmds
		cmd_item_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (cmd_queue.size() != 0
					&& !(cmd_queue[0].drain && (frames_due.size() != 0
						|| (s_axis_tvalid && s_axis_tready
							&& s_axis_tdata[1:0] != CMD_SET_PIXEL)))
					&& $urandom_range(99) >= send_idle_pct) begin
				it = cmd_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {3'b000, it.on, it.y, it.x, it.cmd};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// frame monitor, input predictor and watchdog
	always @(posedge clk) begin : watch_frames
		frame_t exp_f;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (frames_due.size() == 0) begin
					$error("chain_frame: no frame expected, got %h", m_axis_tdata);
					err_count++;
				end else begin
					exp_f = frames_due.pop_front();
					if (m_axis_tdata !== exp_f.chain_frame) begin
						$error("chain_frame: expected %h, got %h", exp_f.chain_frame,
							m_axis_tdata);
						err_count++;
					end
					if (m_axis_tlast !== exp_f.last) begin
						$error("last: expected %b, got %b", exp_f.last, m_axis_tlast);
						err_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_frames(s_axis_tdata);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic add_cmd(input cmd_t op, input logic [3:0] x, input logic [5:0] y,
			input logic on, input bit drain);
		cmd_item_t it;
		it.cmd = op;
		it.x = x;
		it.y = y;
		it.on = on;
		it.drain = drain;
		cmd_queue.push_back(it);
	endtask

	// mostly in-panel pixel writes with an occasional refresh command
	task automatic add_random_cmds(input int count);
		int pick;
		cmd_t op;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				if ($urandom_range(99) < 85)
					add_cmd(CMD_SET_PIXEL, 4'($urandom_range(PANEL_WIDTH - 1)),
						6'($urandom_range(PANEL_HEIGHT - 1)), 1'($urandom_range(1)), 1'b0);
				else
					add_cmd(CMD_SET_PIXEL, 4'($urandom_range(15)), 6'($urandom_range(63)),
						1'($urandom_range(1)), 1'b0);
			end else begin
				op = (pick < 93) ? CMD_FLUSH : (pick < 97) ? CMD_CLEAR : CMD_INIT;
				// don't-care coordinates ride along on refresh commands
				add_cmd(op, 4'($urandom_range(15)), 6'($urandom_range(63)),
					1'($urandom_range(1)), $urandom_range(99) < 10);
			end
		end
	endtask

	// block is idle once every command is taken and every frame is back
	task automatic wait_idle();
		while (cmd_queue.size() != 0 || s_axis_tvalid || frames_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_INTENSITY)
			cfg_intensity = value[3:0];
		else if (addr == ADDR_SCAN)
			cfg_scan = value[2:0];
	endtask

	initial begin
		for (int r = 0; r < PANEL_HEIGHT; r++)
			pixel_rows[r] = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset state, start-up with reset config, panel corners, off-panel writes
		add_cmd(CMD_FLUSH, 4'd0, 6'd0, 1'b0, 1'b0);
		add_cmd(CMD_INIT, 4'd15, 6'd63, 1'b1, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd0, 6'd0, 1'b1, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd7, 6'd31, 1'b1, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd3, 6'd9, 1'b1, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd8, 6'd4, 1'b1, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd15, 6'd63, 1'b1, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd2, 6'd32, 1'b1, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd5, 6'd20, 1'b1, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd5, 6'd20, 1'b0, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd6, 6'd31, 1'b1, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd7, 6'd31, 1'b0, 1'b0);
		add_cmd(CMD_FLUSH, 4'd0, 6'd0, 1'b0, 1'b0);
		add_cmd(CMD_CLEAR, 4'd0, 6'd0, 1'b0, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd1, 6'd15, 1'b1, 1'b0);
		add_cmd(CMD_SET_PIXEL, 4'd4, 6'd24, 1'b1, 1'b0);
		add_cmd(CMD_FLUSH, 4'd0, 6'd0, 1'b0, 1'b1);
		add_cmd(CMD_SET_PIXEL, 4'd0, 6'd8, 1'b1, 1'b0);
		add_cmd(CMD_INIT, 4'd0, 6'd0, 1'b0, 1'b0);
		add_cmd(CMD_FLUSH, 4'd0, 6'd0, 1'b0, 1'b0);
		wait_idle();

		apb_write(ADDR_INTENSITY, {28'($urandom), 4'd15});
		apb_write(ADDR_SCAN, {29'($urandom), 3'd0});
		add_cmd(CMD_INIT, 4'd0, 6'd0, 1'b0, 1'b1);
		add_random_cmds(RANDOM_ITEMS);
		wait_idle();

		send_idle_pct = 68;
		recv_idle_pct = 14;
		apb_write(ADDR_INTENSITY, {28'($urandom), 4'd0});
		apb_write(ADDR_SCAN, {29'($urandom), 3'd7});
		add_cmd(CMD_INIT, 4'd0, 6'd0, 1'b0, 1'b1);
		add_random_cmds(RANDOM_ITEMS);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		apb_write(ADDR_INTENSITY, $urandom);
		apb_write(ADDR_SCAN, $urandom);
		add_cmd(CMD_INIT, 4'd0, 6'd0, 1'b0, 1'b1);
		add_random_cmds(RANDOM_ITEMS);

		while (cmd_queue.size() != 0 || s_axis_tvalid || frames_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && frames_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/lmcr_pkg.sv
rtl/lmcr_ctrl.sv
rtl/lmcr_datapath.sv
rtl/led_matrix_chain_refresher.sv
tb/led_matrix_chain_refresher_tb.sv
